>>> rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared definitions for the tapered polyline strip
// Widths, register codes, reset values and the queued item format.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int LEN_W      = 11;
  localparam int VNUM_W     = 11;
  localparam int THK_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int K_W        = 16;
  localparam int TN_W       = THK_W + K_W + 2;
  localparam int DEN_W      = LEN_W + 1;

  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_QUEUE_DEPTH  = 4;

  localparam logic [THK_W-1:0] MIN_THK_RST = 16'd1024;
  localparam logic [THK_W-1:0] MAX_THK_RST = 16'd2048;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_THK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THK = 1'b1;

  // one classified point handed from front to back
  typedef struct packed {
    logic                     first;
    logic                     fin;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [K_W-1:0]            k;
    logic [DEN_W-1:0]          den;
    logic [TN_W-1:0]           tnum;
  } tps_item_t;

endpackage

>>> rtl/tps_in_if.sv
// ----------------------------------------------------------------------------
// tps_in_if: trail point channel
// Valid/ready channel carrying one trail point per beat.
// ----------------------------------------------------------------------------
interface tps_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [tps_pkg::COORD_W-1:0] point_x;
  logic signed [tps_pkg::COORD_W-1:0] point_y;
  logic [tps_pkg::LEN_W-1:0]          path_length;
  logic                               final_point;

  modport source(output valid, point_x, point_y, path_length, final_point, input ready);
  modport sink(input valid, point_x, point_y, path_length, final_point, output ready);
endinterface

>>> rtl/tps_out_if.sv
// ----------------------------------------------------------------------------
// tps_out_if: strip vertex channel
// Valid/ready channel carrying one strip vertex per beat.
// ----------------------------------------------------------------------------
interface tps_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tps_pkg::COORD_W-1:0] vertex_x;
  logic signed [tps_pkg::COORD_W-1:0] vertex_y;
  logic [tps_pkg::VNUM_W-1:0]         vertex_number;
  logic                               strip_end;

  modport source(output valid, vertex_x, vertex_y, vertex_number, strip_end, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_number, strip_end, output ready);
endinterface

>>> rtl/tapered_polyline_strip.sv
// ----------------------------------------------------------------------------
// tapered_polyline_strip: tapered trail stroke as a triangle strip
// Front intake, item queue and vertex sequencer with its register file.
// ----------------------------------------------------------------------------
// The first point of a trail gives its tail vertex (and the head vertex too
// when it is also the final point); every later point gives its pair (and
// the head vertex on the final point) after squaring, the shared-step square
// root and thickness divider, the direction divider (skipped for a zero
// step), then sign, product and rounding steps, with each vertex loaded
// when the output register is free. A four-entry queue lets points be taken
// while earlier ones are still being worked on. Thickness registers are
// written on the cfg port and should only change between trails.
module tapered_polyline_strip #(
  parameter int MAX_POINTS  = tps_pkg::DEF_MAX_POINTS,
  parameter int QUEUE_DEPTH = tps_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tps_in_if.sink                          in_ch,
  tps_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tps_pkg::*;

  logic [THK_W-1:0] min_thk_r, max_thk_r;
  logic             q_push, q_pop, q_full, q_empty;
  tps_item_t        q_item, q_head;

  // thickness registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_thk_r <= MIN_THK_RST;
      max_thk_r <= MAX_THK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_THK: min_thk_r <= cfg_data;
        REG_MAX_THK: max_thk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tps_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .max_thk (max_thk_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  tps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tps_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .min_thk (min_thk_r),
    .max_thk (max_thk_r),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front: point intake and classification
// Tracks the trail, forms the direction difference and the thickness
// numerator, and pushes one item per accepted beat into the queue.
// ----------------------------------------------------------------------------
module tps_front #(
  parameter int MAX_POINTS = tps_pkg::DEF_MAX_POINTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tps_in_if.sink                       in_ch,
  input  logic [tps_pkg::THK_W-1:0]    max_thk,
  input  logic                         q_full,
  output logic                         q_push,
  output tps_pkg::tps_item_t           q_item
);
  import tps_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS);
  localparam int CMP_W = 18;
  localparam logic [CMP_W-1:0] N_MAX = CMP_W'(MAX_POINTS);
  localparam logic [CMP_W-1:0] K_LIM = CMP_W'(MAX_POINTS - 1);

  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CMP_W-1:0]          n_wide, n_clamp;
  logic [K_W+1:0]            k_term;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // clamp path length into the supported range
  always_comb begin
    n_wide = CMP_W'(in_ch.path_length);
    if (n_wide < CMP_W'(2)) begin
      n_clamp = CMP_W'(2);
    end else if (n_wide > N_MAX) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = n_wide;
    end
  end

  // 4k-3 for the thickness ramp
  assign k_term = ((K_W+2)'(count_r) << 2) - (K_W+2)'(3);

  // item fields
  always_comb begin
    q_item.first = (count_r == '0);
    q_item.fin   = in_ch.final_point;
    q_item.px    = in_ch.point_x;
    q_item.py    = in_ch.point_y;
    q_item.dx    = DIFF_W'(in_ch.point_x) - DIFF_W'(prev_x_r);
    q_item.dy    = DIFF_W'(in_ch.point_y) - DIFF_W'(prev_y_r);
    q_item.k     = K_W'(count_r);
    q_item.den   = {n_clamp[LEN_W-1:0], 1'b0};
    q_item.tnum  = TN_W'(max_thk) * TN_W'(k_term);
  end

  // point counter, saturating near the end of a long trail
  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      if (in_ch.final_point) begin
        count_nxt = '0;
      end else if (CMP_W'(count_r) + CMP_W'(1) <= K_LIM) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (q_push) begin
        prev_x_r <= in_ch.point_x;
        prev_y_r <= in_ch.point_y;
      end
    end
  end

endmodule

>>> rtl/tps_queue.sv
// ----------------------------------------------------------------------------
// tps_queue: item queue between front and back
// Small first-in first-out store of classified points.
// ----------------------------------------------------------------------------
module tps_queue #(
  parameter int DEPTH = tps_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tps_pkg::tps_item_t push_item,
  input  logic               pop,
  output tps_pkg::tps_item_t head,
  output logic               full,
  output logic               empty
);
  import tps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tps_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_push, do_pop;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back: vertex generation
// Sequencer with iterative square root and dividers that turns one queued
// point into its strip vertices and drives the output register.
// ----------------------------------------------------------------------------
module tps_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tps_pkg::tps_item_t        head,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic [tps_pkg::THK_W-1:0] min_thk,
  input  logic [tps_pkg::THK_W-1:0] max_thk,
  tps_out_if.source                 out_ch
);
  import tps_pkg::*;

  localparam int MAG_W      = COORD_W;
  localparam int SQ_W       = 2 * MAG_W + 1;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int NUM_W      = MAG_W + 23;
  localparam int DVS_W      = ROOT_W + 17;
  localparam int Q_W        = 18;
  localparam int U_W        = 18;
  localparam int P_W        = 36;
  localparam int SUM_W      = COORD_W + 2;
  localparam int SQRT_STEPS = 32;
  localparam int IT_STEPS   = (TN_W > SQRT_STEPS) ? TN_W : SQRT_STEPS;
  localparam int DIV_STEPS  = Q_W;
  localparam int STEP_W     = 6;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_ITER = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_SGN  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_RND  = 4'd6;
  localparam logic [3:0] ST_ET   = 4'd7;
  localparam logic [3:0] ST_EA   = 4'd8;
  localparam logic [3:0] ST_EB   = 4'd9;
  localparam logic [3:0] ST_EH   = 4'd10;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

  // round a product half away from zero after a right shift
  function automatic logic signed [U_W-1:0] rnd_shift(input logic signed [P_W-1:0] v,
                                                     input int sh);
    logic [P_W-1:0] m;
    logic [P_W-1:0] r;
    m = v[P_W-1] ? P_W'(-v) : P_W'(v);
    r = (m + (P_W'(1) << (sh - 1))) >> sh;
    return v[P_W-1] ? -U_W'(r) : U_W'(r);
  endfunction

  // clamp a widened sum into the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'(8388607);
    lo = -SUM_W'(8388608);
    if (v > hi) return COORD_W'(hi);
    if (v < lo) return COORD_W'(lo);
    return COORD_W'(v);
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  tps_item_t               it_r, it_nxt;
  logic [MAG_W-1:0]        mx, my;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    zero_r, zero_nxt;
  logic [RAD_W-1:0]        v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt, trial;
  logic [DEN_W-1:0]        trem_r, trem_nxt;
  logic [DEN_W:0]          trem_sh;
  logic [TN_W-1:0]         tnum_r, tnum_nxt, tq_r, tq_nxt;
  logic [THK_W-1:0]        th_r, th_nxt;
  logic [NUM_W-1:0]        remx_r, remx_nxt, remy_r, remy_nxt;
  logic [DVS_W-1:0]        dvs_r, dvs_nxt;
  logic [Q_W-1:0]          qx_r, qx_nxt, qy_r, qy_nxt, qxc, qyc;
  logic signed [U_W-1:0]   ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [P_W-1:0]   pox_r, pox_nxt, poy_r, poy_nxt, phx_r, phx_nxt, phy_r, phy_nxt;
  logic signed [U_W-1:0]   ox_r, ox_nxt, oy_r, oy_nxt, hx_r, hx_nxt, hy_r, hy_nxt;
  logic [VNUM_W-1:0]       k11, num_lo, num_hi, num_head;
  logic                    slot_free, load;
  logic signed [COORD_W-1:0] ld_x, ld_y, vx_r, vy_r;
  logic [VNUM_W-1:0]       ld_n, vn_r;
  logic                    ld_end, end_r, out_valid_r;

  assign mx = it_r.dx[DIFF_W-1] ? MAG_W'(-it_r.dx) : MAG_W'(it_r.dx);
  assign my = it_r.dy[DIFF_W-1] ? MAG_W'(-it_r.dy) : MAG_W'(it_r.dy);

  assign trial   = res_r + bit_r;
  assign trem_sh = {trem_r, tnum_r[TN_W-1]};

  // vertex numbers of this point, modulo the strip counter width
  assign k11      = VNUM_W'(it_r.k);
  assign num_hi   = {k11[VNUM_W-2:0], 1'b0};
  assign num_lo   = num_hi - VNUM_W'(1);
  assign num_head = num_hi | VNUM_W'(1);

  // clamped quotient magnitudes
  assign qxc = (qx_r > Q_ONE) ? Q_ONE : qx_r;
  assign qyc = (qy_r > Q_ONE) ? Q_ONE : qy_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    it_nxt    = it_r;
    sq_nxt    = sq_r;
    zero_nxt  = zero_r;
    v_nxt     = v_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    trem_nxt  = trem_r;
    tnum_nxt  = tnum_r;
    tq_nxt    = tq_r;
    th_nxt    = th_r;
    remx_nxt  = remx_r;
    remy_nxt  = remy_r;
    dvs_nxt   = dvs_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    ux_nxt    = ux_r;
    uy_nxt    = uy_r;
    pox_nxt   = pox_r;
    poy_nxt   = poy_r;
    phx_nxt   = phx_r;
    phy_nxt   = phy_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    load      = 1'b0;
    ld_x      = it_r.px;
    ld_y      = it_r.py;
    ld_n      = '0;
    ld_end    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          it_nxt   = head;
          step_nxt = '0;
          ox_nxt   = '0;
          oy_nxt   = '0;
          hx_nxt   = '0;
          hy_nxt   = '0;
          state_nxt = head.first ? ST_ET : ST_SQ;
        end
      end

      // squared length, one multiplier per cycle
      ST_SQ: begin
        if (step_r == '0) begin
          sq_nxt   = SQ_W'(mx) * SQ_W'(mx);
          step_nxt = STEP_W'(1);
        end else begin
          sq_nxt    = sq_r + SQ_W'(my) * SQ_W'(my);
          zero_nxt  = (sq_nxt == '0);
          v_nxt     = RAD_W'(sq_nxt) << 14;
          res_nxt   = '0;
          bit_nxt   = RAD_W'(1) << 62;
          trem_nxt  = '0;
          tnum_nxt  = it_r.tnum;
          tq_nxt    = '0;
          step_nxt  = '0;
          state_nxt = ST_ITER;
        end
      end

      // square root and thickness division side by side
      ST_ITER: begin
        if (step_r < STEP_W'(SQRT_STEPS)) begin
          if (v_r >= trial) begin
            v_nxt   = v_r - trial;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
        if (step_r < STEP_W'(TN_W)) begin
          if (trem_sh >= {1'b0, it_r.den}) begin
            trem_nxt = DEN_W'(trem_sh - {1'b0, it_r.den});
            tq_nxt   = {tq_r[TN_W-2:0], 1'b1};
          end else begin
            trem_nxt = DEN_W'(trem_sh);
            tq_nxt   = {tq_r[TN_W-2:0], 1'b0};
          end
          tnum_nxt = tnum_r << 1;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(IT_STEPS - 1)) begin
          step_nxt = '0;
          remx_nxt = {mx, 23'b0};
          remy_nxt = {my, 23'b0};
          dvs_nxt  = {res_r[ROOT_W-1:0], 17'b0};
          qx_nxt   = '0;
          qy_nxt   = '0;
          state_nxt = zero_r ? ST_SGN : ST_DIV;
        end
      end

      // unit direction, one quotient bit per cycle for each axis
      ST_DIV: begin
        if ({2'b0, remx_r} >= dvs_r) begin
          remx_nxt = NUM_W'({2'b0, remx_r} - dvs_r);
          qx_nxt   = {qx_r[Q_W-2:0], 1'b1};
        end else begin
          qx_nxt   = {qx_r[Q_W-2:0], 1'b0};
        end
        if ({2'b0, remy_r} >= dvs_r) begin
          remy_nxt = NUM_W'({2'b0, remy_r} - dvs_r);
          qy_nxt   = {qy_r[Q_W-2:0], 1'b1};
        end else begin
          qy_nxt   = {qy_r[Q_W-2:0], 1'b0};
        end
        dvs_nxt  = dvs_r >> 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SGN;
        end
      end

      // signs, clamp and final thickness
      ST_SGN: begin
        if (zero_r) begin
          ux_nxt = '0;
          uy_nxt = '0;
        end else begin
          ux_nxt = it_r.dx[DIFF_W-1] ? -U_W'(qxc) : U_W'(qxc);
          uy_nxt = it_r.dy[DIFF_W-1] ? -U_W'(qyc) : U_W'(qyc);
        end
        if (tq_r > TN_W'(16'hFFFF)) begin
          th_nxt = 16'hFFFF;
        end else if (THK_W'(tq_r) < min_thk) begin
          th_nxt = min_thk;
        end else begin
          th_nxt = THK_W'(tq_r);
        end
        state_nxt = ST_MUL;
      end

      // offset and head products
      ST_MUL: begin
        pox_nxt   = P_W'(uy_r) * $signed({{(P_W-THK_W){1'b0}}, th_r});
        poy_nxt   = P_W'(ux_r) * $signed({{(P_W-THK_W){1'b0}}, th_r});
        phx_nxt   = P_W'(ux_r) * $signed({{(P_W-THK_W){1'b0}}, max_thk});
        phy_nxt   = P_W'(uy_r) * $signed({{(P_W-THK_W){1'b0}}, max_thk});
        state_nxt = ST_RND;
      end

      ST_RND: begin
        ox_nxt    = -rnd_shift(pox_r, 17);
        oy_nxt    = rnd_shift(poy_r, 17);
        hx_nxt    = rnd_shift(phx_r, 16);
        hy_nxt    = rnd_shift(phy_r, 16);
        state_nxt = ST_EA;
      end

      // tail vertex
      ST_ET: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_n      = '0;
          state_nxt = it_r.fin ? ST_EH : ST_IDLE;
        end
      end

      ST_EA: begin
        ld_x = sat_coord(SUM_W'(it_r.px) - SUM_W'(ox_r));
        ld_y = sat_coord(SUM_W'(it_r.py) - SUM_W'(oy_r));
        ld_n = num_lo;
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_EB;
        end
      end

      ST_EB: begin
        ld_x = sat_coord(SUM_W'(it_r.px) + SUM_W'(ox_r));
        ld_y = sat_coord(SUM_W'(it_r.py) + SUM_W'(oy_r));
        ld_n = num_hi;
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = it_r.fin ? ST_EH : ST_IDLE;
        end
      end

      // head vertex closes the strip
      ST_EH: begin
        ld_x   = sat_coord(SUM_W'(it_r.px) + SUM_W'(hx_r));
        ld_y   = sat_coord(SUM_W'(it_r.py) + SUM_W'(hy_r));
        ld_n   = num_head;
        ld_end = 1'b1;
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    sq_r   <= sq_nxt;
    zero_r <= zero_nxt;
    v_r    <= v_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    trem_r <= trem_nxt;
    tnum_r <= tnum_nxt;
    tq_r   <= tq_nxt;
    th_r   <= th_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    dvs_r  <= dvs_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    ux_r   <= ux_nxt;
    uy_r   <= uy_nxt;
    pox_r  <= pox_nxt;
    poy_r  <= poy_nxt;
    phx_r  <= phx_nxt;
    phy_r  <= phy_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    hx_r   <= hx_nxt;
    hy_r   <= hy_nxt;
    if (load) begin
      vx_r  <= ld_x;
      vy_r  <= ld_y;
      vn_r  <= ld_n;
      end_r <= ld_end;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.vertex_x      = vx_r;
  assign out_ch.vertex_y      = vy_r;
  assign out_ch.vertex_number = vn_r;
  assign out_ch.strip_end     = end_r;

endmodule

>>> tb/tb_tapered_polyline_strip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tapered_polyline_strip: self-checking bench for the trail stroke block
// Trail points go in on a valid/ready channel with random gaps when enabled. A local
// predictor of the strip vertices fills a queue of expected vertices, and
// every vertex beat is compared field by field against the oldest entry.
// Thickness registers are changed between trails only, once the block is idle.
// ----------------------------------------------------------------------------
module tb_tapered_polyline_strip;
  import tps_pkg::*;

  localparam int  TRAIL_MAX   = 1024;
  localparam int  DRAIN_WAIT  = 100;
  localparam int  CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [VNUM_W-1:0]         num;
    logic                      strip_end;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tps_in_if  in_ch();
  tps_out_if out_ch();

  tapered_polyline_strip dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  vertex_t     expected_vertices[$];
  longint      last_x, last_y;
  int unsigned trail_pos;
  longint      thk_min, thk_max;

  int  fail_count;
  int  cycle_count;
  bit  gaps_on;
  int  hold_cycles;
  int  recv_wait;

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    cycle_count = 0;
    forever begin
      #5 clk = 1'b1;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[tapered_polyline_strip] ERROR");
        $finish;
      end
      #5 clk = 1'b0;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint abs_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // shift right rounding half away from zero
  function automatic longint round_shift(longint v, int sh);
    longint m;
    m = (abs_of(v) + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [COORD_W-1:0] clip24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[COORD_W-1:0];
  endfunction

  function automatic void add_vertex(longint x, longint y, longint num, bit last);
    vertex_t v;
    v.x = clip24(x);
    v.y = clip24(y);
    v.num = num[VNUM_W-1:0];
    v.strip_end = last;
    expected_vertices.push_back(v);
  endfunction

  // unit direction in Q1.16, zero vector gives zero
  function automatic void direction_of(longint dx, longint dy, output longint ux,
                                       output longint uy);
    longint unsigned mx, my, s, l7, qx, qy;
    mx = abs_of(dx);
    my = abs_of(dy);
    s = mx * mx + my * my;
    if (s == 0) begin
      ux = 0;
      uy = 0;
      return;
    end
    l7 = int_sqrt(s << 14);
    qx = (mx << 23) / l7;
    qy = (my << 23) / l7;
    if (qx > 65536) qx = 65536;
    if (qy > 65536) qy = 65536;
    ux = (dx < 0) ? -longint'(qx) : longint'(qx);
    uy = (dy < 0) ? -longint'(qy) : longint'(qy);
  endfunction

  function automatic void predict_strip(logic signed [COORD_W-1:0] px_in,
                                        logic signed [COORD_W-1:0] py_in,
                                        logic [LEN_W-1:0] len, logic fin);
    longint px, py, n, k, th, ux, uy, ox, oy;
    px = px_in;
    py = py_in;
    n = len;
    if (n < 2) n = 2;
    if (n > TRAIL_MAX) n = TRAIL_MAX;
    // tail vertex opens a trail
    if (trail_pos == 0) begin
      add_vertex(px, py, 0, 1'b0);
      last_x = px;
      last_y = py;
      if (fin) add_vertex(px, py, 1, 1'b1);
      else trail_pos = 1;
      return;
    end
    k = trail_pos;
    th = (thk_max * (4 * k - 3)) / (2 * n);
    if (th < thk_min) th = thk_min;
    if (th > 65535) th = 65535;
    direction_of(px - last_x, py - last_y, ux, uy);
    ox = round_shift(-uy * th, 17);
    oy = round_shift(ux * th, 17);
    add_vertex(px - ox, py - oy, 2 * k - 1, 1'b0);
    add_vertex(px + ox, py + oy, 2 * k, 1'b0);
    last_x = px;
    last_y = py;
    if (fin) begin
      add_vertex(px + round_shift(ux * thk_max, 16), py + round_shift(uy * thk_max, 16),
                 2 * k + 1, 1'b1);
      trail_pos = 0;
    end else if (k + 1 <= TRAIL_MAX - 1) begin
      trail_pos = k + 1;
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  // ready drops for a random wait after each beat when gaps are on, and for any long hold
  initial begin
    out_ch.ready = 1'b0;
    recv_wait = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        recv_wait = gaps_on ? $urandom_range(0, 7) : 0;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // vertex checker
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_vertices.size() == 0) begin
        $error("unexpected vertex beat x=%0d y=%0d number=%0d", out_ch.vertex_x,
               out_ch.vertex_y, out_ch.vertex_number);
        fail_count++;
      end else begin
        want = expected_vertices.pop_front();
        if (out_ch.vertex_x !== want.x) begin
          $error("vertex_x expected %0d actual %0d", want.x, out_ch.vertex_x);
          fail_count++;
        end
        if (out_ch.vertex_y !== want.y) begin
          $error("vertex_y expected %0d actual %0d", want.y, out_ch.vertex_y);
          fail_count++;
        end
        if (out_ch.vertex_number !== want.num) begin
          $error("vertex_number expected %0d actual %0d", want.num, out_ch.vertex_number);
          fail_count++;
        end
        if (out_ch.strip_end !== want.strip_end) begin
          $error("strip_end expected %0d actual %0d", want.strip_end, out_ch.strip_end);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic [LEN_W-1:0] len, logic fin);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.point_x     <= x;
    in_ch.point_y     <= y;
    in_ch.path_length <= len;
    in_ch.final_point <= fin;
    do @(posedge clk); while (!in_ch.ready);
    predict_strip(x, y, len, fin);
  endtask

  // let the block drain before a register write
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_MIN_THK) thk_min = val;
    else thk_max = val;
  endtask

  task automatic set_widths(logic [15:0] lo, logic [15:0] hi);
    settle();
    write_reg(REG_MIN_THK, lo);
    write_reg(REG_MAX_THK, hi);
  endtask

  // trail of random steps up to the given size
  task automatic send_trail(int pts, logic [LEN_W-1:0] len, int step);
    logic signed [COORD_W-1:0] x, y;
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    for (int i = 0; i < pts; i++) begin
      send_point(x, y, len, i == pts - 1);
      x = x + COORD_W'(int'($urandom_range(0, 2 * step)) - step);
      y = y + COORD_W'(int'($urandom_range(0, 2 * step)) - step);
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_default_widths();
    send_point(24'sd0, 24'sd0, 11'd4, 1'b0);
    send_point(24'sd2560, 24'sd0, 11'd4, 1'b0);
    send_point(24'sd2560, 24'sd2560, 11'd4, 1'b0);
    send_point(24'sd0, -24'sd256, 11'd4, 1'b1);
  endtask

  task automatic test_special_points();
    // final on the first point
    send_point(24'sd1000, -24'sd1000, 11'd2, 1'b1);
    // zero-length direction, then a trail ending early
    send_point(24'sd77, 24'sd77, 11'd8, 1'b0);
    send_point(24'sd77, 24'sd77, 11'd8, 1'b0);
    send_point(24'sd77, 24'sd77, 11'd8, 1'b1);
    // path length outside the legal range
    send_point(24'sd0, 24'sd0, 11'd0, 1'b0);
    send_point(24'sd300, 24'sd100, 11'd1, 1'b0);
    send_point(24'sd600, 24'sd900, 11'd2047, 1'b1);
  endtask

  task automatic test_coordinate_extremes();
    send_point(24'sh800000, 24'sh800000, 11'd3, 1'b0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 11'd3, 1'b0);
    send_point(24'sh800000, 24'sh7FFFFF, 11'd3, 1'b1);
    send_point(24'sh7FFFFF, 24'sh800000, 11'd1024, 1'b0);
    send_point(24'sh7FFFFF, 24'sh7FFFFE, 11'd1024, 1'b1);
  endtask

  task automatic test_width_settings();
    set_widths(16'd0, 16'd0);
    send_trail(3, 11'd3, 4000);
    set_widths(16'hFFFF, 16'hFFFF);
    send_trail(4, 11'd4, 4000);
    // thickness overflows the register range with a short length
    set_widths(16'd0, 16'hFFFF);
    send_trail(6, 11'd2, 200000);
    set_widths(16'd3000, 16'd500);
    send_trail(4, 11'd4, 2000);
    set_widths(16'd1024, 16'd2048);
  endtask

  // walks past the point counter ceiling
  task automatic test_overlong_trail();
    gaps_on = 1'b0;
    send_trail(1030, 11'd1024, 300);
    gaps_on = 1'b1;
  endtask

  task automatic test_output_hold();
    settle();
    hold_cycles = 400;
    send_trail(12, 11'd12, 5000);
  endtask

  task automatic test_random_trails();
    int sent, pts, len, step;
    sent = 0;
    while (sent < 120) begin
      if (sent > 40 && sent < 70) gaps_on = 1'b0;
      else gaps_on = 1'b1;
      pts  = $urandom_range(1, 9);
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : pts;
      step = ($urandom_range(0, 5) == 0) ? 8388607 : $urandom_range(1, 20000);
      send_trail(pts, LEN_W'(len), step);
      sent += pts;
    end
    gaps_on = 1'b1;
    set_widths(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_trail(8, 11'd8, 50000);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.path_length = '0;
    in_ch.final_point = 1'b0;
    fail_count = 0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    last_x = 0;
    last_y = 0;
    trail_pos = 0;
    thk_min = MIN_THK_RST;
    thk_max = MAX_THK_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_widths();
    test_special_points();
    test_coordinate_extremes();
    test_width_settings();
    test_output_hold();
    test_overlong_trail();
    test_random_trails();
    settle();

    if (fail_count == 0)
      $display("[tapered_polyline_strip] OK");
    else
      $display("[tapered_polyline_strip] ERROR");
    $finish;
  end

endmodule
